// ===== hdl/linear_run_detector_defines.svh =====
// Assertion macros for the linear run detector.
// Taken in by the files that check their own logic; needs a clk and rst in scope.
`ifndef LINEAR_RUN_DETECTOR_DEFINES_SVH
`define LINEAR_RUN_DETECTOR_DEFINES_SVH

// Checked on every rising edge outside reset
`define LRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included
`define LRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lrd_pkg.sv =====
// Shared widths, the tolerance reset value and the run word type of the linear run detector.
// No dependencies.
package lrd_pkg;

  localparam int DIST_W    = 20;   // range sample, 1/4096 m
  localparam int TOL_W     = 21;   // tolerance register
  localparam int RUN_IDX_W = 11;   // reported index width
  localparam int D2_W      = 23;   // signed second difference
  localparam int MAG_W     = 22;   // magnitude of the second difference

  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 21'd4;

  // One run report from the core to the result register
  typedef struct packed {
    logic                 emit;
    logic [RUN_IDX_W-1:0] start;
    logic [RUN_IDX_W-1:0] stop;
  } run_t;

endpackage

// ===== hdl/linear_run_detector.sv =====
// Top level of the linear run detector: input register, core, result register.
// Depends on lrd_pkg, lrd_core and linear_run_detector_defines.svh.
//
// Usage: range samples of a scan enter on the input channel (in_valid,
// in_stall, distance), one word per accepted edge, in scan order. Each
// time a run of points with small second difference ends, one word
// (run_start, run_stop) leaves on the output channel (out_valid, out_stall).
// The tolerance register is written through cfg_we / cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// A sample is taken into the input register at its accepting edge and its
// run word, if any, is loaded into the result register once the pipe
// advances. Throughput: one word per cycle; the input register and the core
// step together whenever the result register is empty or being taken, so
// the result register sets the pace.
// When the receiver stalls a full result register, the pipe holds and
// in_stall rises once the input register is also occupied.
// Reset clears the sample history, the point index, any open run, both
// pipeline valids and sets the tolerance to 4 (1/4096 m units).
`include "linear_run_detector_defines.svh"

module linear_run_detector
  import lrd_pkg::*;
#(
  parameter int SCAN_POINTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DIST_W-1:0]    distance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RUN_IDX_W-1:0] run_start,
  output logic [RUN_IDX_W-1:0] run_stop,
  input  logic                 cfg_we,
  input  logic [TOL_W-1:0]     cfg_wdata
);

  logic [TOL_W-1:0]  tolerance;
  logic              s1_valid;
  logic [DIST_W-1:0] s1_distance;
  logic              advance;
  logic              step;
  run_t              run;

  // Pipe moves when the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_distance <= distance;
    end
  end

  lrd_core #(
    .SCAN_POINTS (SCAN_POINTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .distance  (s1_distance),
    .tolerance (tolerance),
    .run       (run)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && run.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && run.emit) begin
      run_start <= run.start;
      run_stop  <= run.stop;
    end
  end

  // Checks
  `LRD_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall, "stall with empty output")
  `LRD_ASSERT(a_stall_needs_word, in_stall |-> (s1_valid && out_valid && out_stall), "no word")
  `LRD_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !s1_valid), "pipe not empty")

endmodule

// ===== hdl/lrd_core.sv =====
// Second difference, linearity test and run tracking for the linear run detector.
// Depends on lrd_pkg.
module lrd_core
  import lrd_pkg::*;
#(
  parameter int SCAN_POINTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [DIST_W-1:0] distance,
  input  logic [TOL_W-1:0]  tolerance,
  output run_t              run
);

  localparam int IDX_W = $clog2(SCAN_POINTS);
  localparam int SUM_W = (IDX_W > RUN_IDX_W) ? IDX_W : RUN_IDX_W;

  logic [DIST_W-1:0]    older_sample;
  logic [DIST_W-1:0]    newer_sample;
  logic [IDX_W-1:0]     point_index;
  logic                 run_open;
  logic [RUN_IDX_W-1:0] open_run_start;

  logic [IDX_W-1:0]     point_index_next;
  logic                 run_open_next;
  logic [RUN_IDX_W-1:0] open_run_start_next;

  logic signed [D2_W-1:0] d2;
  logic [D2_W-1:0]        d2_abs;
  logic [MAG_W-1:0]       mag;
  logic                   have_d2;
  logic                   linear;
  logic                   last;
  logic [IDX_W-1:0]       i_idx;
  logic [SUM_W-1:0]       i_ext;
  logic [SUM_W-1:0]       i_plus1;
  logic [SUM_W-1:0]       i_plus2;
  logic [RUN_IDX_W-1:0]   cur_start;

  // Second difference and its magnitude
  always_comb begin
    d2 = $signed({3'b000, distance}) - $signed({2'b00, newer_sample, 1'b0})
       + $signed({3'b000, older_sample});
    d2_abs = d2[D2_W-1] ? (-d2) : d2;
    mag    = d2_abs[MAG_W-1:0];
    linear = mag < {1'b0, tolerance};
  end

  // Index arithmetic
  always_comb begin
    have_d2 = point_index >= IDX_W'(2);
    last    = point_index == IDX_W'(SCAN_POINTS - 1);
    i_idx   = point_index - IDX_W'(2);
    i_ext   = SUM_W'(i_idx);
    i_plus1 = i_ext + SUM_W'(1);
    i_plus2 = i_ext + SUM_W'(2);
  end

  // Run open / close and next state
  always_comb begin
    run_open_next       = run_open;
    open_run_start_next = open_run_start;
    cur_start           = run_open ? open_run_start : i_ext[RUN_IDX_W-1:0];
    run.emit  = 1'b0;
    run.start = cur_start;
    run.stop  = i_plus1[RUN_IDX_W-1:0];

    if (have_d2) begin
      if (linear && !run_open) begin
        run_open_next       = 1'b1;
        open_run_start_next = i_ext[RUN_IDX_W-1:0];
      end
      if (!linear && run_open && !last) begin
        run.emit      = 1'b1;
        run.stop      = i_plus1[RUN_IDX_W-1:0];
        run_open_next = 1'b0;
      end else if ((!linear || last) && (run_open || linear)) begin
        run.emit      = 1'b1;
        run.stop      = i_plus2[RUN_IDX_W-1:0];
        run_open_next = 1'b0;
      end
    end

    // Scan wrap
    if (last) begin
      point_index_next = '0;
      run_open_next    = 1'b0;
    end else begin
      point_index_next = point_index + IDX_W'(1);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample   <= '0;
      newer_sample   <= '0;
      point_index    <= '0;
      run_open       <= 1'b0;
      open_run_start <= '0;
    end else if (step) begin
      older_sample   <= newer_sample;
      newer_sample   <= distance;
      point_index    <= point_index_next;
      run_open       <= run_open_next;
      open_run_start <= open_run_start_next;
    end
  end

endmodule
